FILE: rtl/rce_pkg.sv
package rce_pkg;

    // position format: POS_FRAC_BITS fraction bits on the start point
    localparam int POS_FRAC_BITS = 8;

    localparam int NUM_AXES = 3;
    localparam int START_W  = 32;
    localparam int DIR_W    = 16;
    localparam int CUBE_W   = 24;
    localparam int FACE_W   = 3;

    // positions compared with POS_FRAC_BITS + 1 fraction bits
    localparam int POS2_W  = START_W + 1;
    localparam int CUBE2_W = CUBE_W + POS_FRAC_BITS + 1;
    localparam int CMP_W   = ((CUBE2_W > POS2_W) ? CUBE2_W : POS2_W) + 2;
    localparam int DIST_W  = CMP_W - 1;
    localparam int PROD_W  = DIST_W + DIR_W;

    // half the cube size in the compare format
    localparam logic signed [CMP_W-1:0] HALF_SIZE = CMP_W'(1) << POS_FRAC_BITS;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef logic [FACE_W-1:0] face_t;

    localparam face_t FACE_POS_Y = 3'd0;
    localparam face_t FACE_NEG_Y = 3'd1;
    localparam face_t FACE_NEG_X = 3'd2;
    localparam face_t FACE_POS_X = 3'd3;
    localparam face_t FACE_POS_Z = 3'd4;
    localparam face_t FACE_NEG_Z = 3'd5;

    // per-axis entry candidate
    typedef struct packed {
        logic                cand;
        face_t               face;
        logic [DIST_W-1:0]   span;
        logic [DIR_W-1:0]    mag;
    } rce_axis_t;

    typedef rce_axis_t [NUM_AXES-1:0] rce_axes_t;

    // cross products, named d<span axis>_v<magnitude axis>
    typedef struct packed {
        logic [NUM_AXES-1:0]   cand;
        face_t [NUM_AXES-1:0]  face;
        logic [PROD_W-1:0]     dy_vx;
        logic [PROD_W-1:0]     dx_vy;
        logic [PROD_W-1:0]     dz_vx;
        logic [PROD_W-1:0]     dx_vz;
        logic [PROD_W-1:0]     dz_vy;
        logic [PROD_W-1:0]     dy_vz;
    } rce_prod_t;

    function automatic face_t low_face(input logic [1:0] axis);
        face_t f;
        unique case (axis)
            AXIS_X:  f = FACE_NEG_X;
            AXIS_Y:  f = FACE_NEG_Y;
            AXIS_Z:  f = FACE_NEG_Z;
            default: f = FACE_POS_Y;
        endcase
        return f;
    endfunction

    function automatic face_t high_face(input logic [1:0] axis);
        face_t f;
        unique case (axis)
            AXIS_X:  f = FACE_POS_X;
            AXIS_Y:  f = FACE_POS_Y;
            AXIS_Z:  f = FACE_POS_Z;
            default: f = FACE_POS_Y;
        endcase
        return f;
    endfunction

endpackage

FILE: rtl/ray_cube_entry_face.sv
// ray_cube_entry_face: face through which a ray enters a unit cube
//
// input channel: in_valid / in_ready carry one word per ray: start point
// (start_x/y/z), direction (dir_x/y/z, only magnitudes matter) and the
// integer cube center (cube_x/y/z)
// output channel: out_valid / out_ready carry entry_face and start_inside
// for each ray, in input order
// three register stages: entry distances, cross products, face select;
// a word passes the distance, product and face registers in turn to reach the output
// throughput is one ray per clock while out_ready stays high; the six 34x16 cross multipliers of the
// middle stage are the widest logic between registers
// a stall on out_ready holds the last stage; earlier stages keep filling
// bubbles, so in_ready only drops once all three stages hold a word
// reset (rst_n low) clears the stage valid bits and drops out_valid; the
// block keeps no other state between rays
module ray_cube_entry_face
    import rce_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [START_W-1:0] start_x,
    input  logic signed [START_W-1:0] start_y,
    input  logic signed [START_W-1:0] start_z,
    input  logic signed [DIR_W-1:0]   dir_x,
    input  logic signed [DIR_W-1:0]   dir_y,
    input  logic signed [DIR_W-1:0]   dir_z,
    input  logic signed [CUBE_W-1:0]  cube_x,
    input  logic signed [CUBE_W-1:0]  cube_y,
    input  logic signed [CUBE_W-1:0]  cube_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [FACE_W-1:0]         entry_face,
    output logic                      start_inside
);

    // stage enables: a stage loads when it is empty or its word moves on
    logic en_dist;
    logic en_prod;
    logic en_pick;

    logic      dist_valid;
    rce_axes_t dist_axes;
    logic      prod_valid;
    rce_prod_t prod_data;

    logic [NUM_AXES-1:0][START_W-1:0] start_vec;
    logic [NUM_AXES-1:0][DIR_W-1:0]   dir_vec;
    logic [NUM_AXES-1:0][CUBE_W-1:0]  cube_vec;

    assign start_vec = {start_z, start_y, start_x};
    assign dir_vec   = {dir_z, dir_y, dir_x};
    assign cube_vec  = {cube_z, cube_y, cube_x};

    assign en_pick  = !out_valid || out_ready;
    assign en_prod  = !prod_valid || en_pick;
    assign en_dist  = !dist_valid || en_prod;
    assign in_ready = en_dist;

    // stage 1: slab tests and entry distance per axis
    rce_dist_stage u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_dist),
        .valid_in  (in_valid),
        .start     (start_vec),
        .dir       (dir_vec),
        .cube      (cube_vec),
        .valid_reg (dist_valid),
        .axes_reg  (dist_axes)
    );

    // stage 2: all pairwise cross products, so no divide is needed
    rce_prod_stage u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en_prod),
        .valid_in  (dist_valid),
        .axes      (dist_axes),
        .valid_reg (prod_valid),
        .prod_reg  (prod_data)
    );

    // stage 3: scan x, y, z and keep the farthest entry; doubles as output register
    rce_pick_stage u_pick (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en_pick),
        .valid_in   (prod_valid),
        .prod       (prod_data),
        .valid_reg  (out_valid),
        .face_reg   (entry_face),
        .inside_reg (start_inside)
    );

endmodule

FILE: rtl/rce_dist_stage.sv
module rce_dist_stage
    import rce_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              valid_in,
    input  logic [NUM_AXES-1:0][START_W-1:0]  start,
    input  logic [NUM_AXES-1:0][DIR_W-1:0]    dir,
    input  logic [NUM_AXES-1:0][CUBE_W-1:0]   cube,
    output logic                              valid_reg,
    output rce_axes_t                         axes_reg
);

    rce_axes_t axes_next;

    genvar a;
    generate
        for (a = 0; a < NUM_AXES; a++) begin : g_axis
            logic signed [CMP_W-1:0] s2;
            logic signed [CMP_W-1:0] c2;
            logic signed [CMP_W-1:0] lo;
            logic signed [CMP_W-1:0] hi;
            logic signed [CMP_W-1:0] diff_lo;
            logic signed [CMP_W-1:0] diff_hi;
            logic                    below;
            logic                    above;
            logic [DIR_W-1:0]        mag;
            logic [DIST_W-1:0]       span;
            face_t                   face;

            assign s2 = $signed({{(CMP_W-START_W){start[a][START_W-1]}}, start[a]}) <<< 1;
            assign c2 = $signed({{(CMP_W-CUBE_W){cube[a][CUBE_W-1]}}, cube[a]})
                        <<< (POS_FRAC_BITS + 1);
            assign lo = c2 - HALF_SIZE;
            assign hi = c2 + HALF_SIZE;

            assign below   = (s2 <= lo);
            assign above   = (s2 >= hi);
            assign diff_lo = lo - s2;
            assign diff_hi = s2 - hi;

            assign span = below ? diff_lo[DIST_W-1:0] : diff_hi[DIST_W-1:0];
            assign face = below ? low_face(2'(a)) : high_face(2'(a));
            // -32768 comes out as 32768 unsigned
            assign mag  = dir[a][DIR_W-1] ? (~dir[a] + DIR_W'(1)) : dir[a];

            assign axes_next[a] = {below | above, face, span, mag};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_in)
        begin
            axes_reg <= axes_next;
        end
    end

endmodule

FILE: rtl/rce_prod_stage.sv
module rce_prod_stage
    import rce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       valid_in,
    input  rce_axes_t  axes,
    output logic       valid_reg,
    output rce_prod_t  prod_reg
);

    rce_prod_t prod_next;

    always_comb
    begin
        prod_next.cand = {axes[AXIS_Z].cand, axes[AXIS_Y].cand, axes[AXIS_X].cand};
        prod_next.face = {axes[AXIS_Z].face, axes[AXIS_Y].face, axes[AXIS_X].face};
        prod_next.dy_vx = PROD_W'(axes[AXIS_Y].span) * PROD_W'(axes[AXIS_X].mag);
        prod_next.dx_vy = PROD_W'(axes[AXIS_X].span) * PROD_W'(axes[AXIS_Y].mag);
        prod_next.dz_vx = PROD_W'(axes[AXIS_Z].span) * PROD_W'(axes[AXIS_X].mag);
        prod_next.dx_vz = PROD_W'(axes[AXIS_X].span) * PROD_W'(axes[AXIS_Z].mag);
        prod_next.dz_vy = PROD_W'(axes[AXIS_Z].span) * PROD_W'(axes[AXIS_Y].mag);
        prod_next.dy_vz = PROD_W'(axes[AXIS_Y].span) * PROD_W'(axes[AXIS_Z].mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_in)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

FILE: rtl/rce_pick_stage.sv
module rce_pick_stage
    import rce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       valid_in,
    input  rce_prod_t  prod,
    output logic       valid_reg,
    output face_t      face_reg,
    output logic       inside_reg
);

    logic  y_wins;
    logic  have_xy;
    logic  z_ge;
    logic  z_wins;
    face_t face_next;
    logic  inside_next;

    // later axis takes ties
    assign y_wins  = prod.cand[AXIS_Y] && (!prod.cand[AXIS_X] || (prod.dy_vx >= prod.dx_vy));
    assign have_xy = prod.cand[AXIS_X] | prod.cand[AXIS_Y];
    assign z_ge    = y_wins ? (prod.dz_vy >= prod.dy_vz) : (prod.dz_vx >= prod.dx_vz);
    assign z_wins  = prod.cand[AXIS_Z] && (!have_xy || z_ge);

    always_comb
    begin
        if (z_wins)
        begin
            face_next = prod.face[AXIS_Z];
        end
        else if (y_wins)
        begin
            face_next = prod.face[AXIS_Y];
        end
        else if (prod.cand[AXIS_X])
        begin
            face_next = prod.face[AXIS_X];
        end
        else
        begin
            face_next = FACE_POS_Y;
        end
        inside_next = ~(have_xy | prod.cand[AXIS_Z]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && valid_in)
        begin
            face_reg   <= face_next;
            inside_reg <= inside_next;
        end
    end

endmodule
